>>> src/swd_pkg.sv
package swd_pkg;

	localparam int SAMPLE_W = 24;
	localparam int DRIVE_W  = 16;
	localparam int FRAC_S   = SAMPLE_W - 1;
	localparam int FRAC_D   = DRIVE_W - 4;

	localparam int ROOT_N   = SAMPLE_W;
	localparam int REM_W    = ROOT_N + 2;
	localparam int DROOT_W  = DRIVE_W - 2;
	localparam int DREM_W   = DROOT_W + 2;
	localparam int DCNT_W   = $clog2(DROOT_W + 1);
	localparam int PROD1_W  = ROOT_N + DROOT_W;
	localparam int PROD2_W  = ROOT_N + DRIVE_W;
	localparam int MAG_W    = PROD2_W + 1 - FRAC_D;

	localparam logic [DRIVE_W-1:0] DRIVE_ONE = DRIVE_W'(1) << FRAC_D;
	localparam logic [DROOT_W-1:0] DROOT_ONE = DROOT_W'(1) << FRAC_D;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       block_end;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       clipped;
		logic                       block_end_out;
	} out_item_t;

	typedef struct packed {
		logic              neg;
		logic [ROOT_N-1:0] mag;
		logic              block_end;
		logic [REM_W-1:0]  rem;
		logic [ROOT_N-1:0] root;
	} root_stage_t;

endpackage

>>> src/sqrt_waveshaper_distortion.sv
// Square-root waveshaper: each sample x gives sign(x) * (|x|*sqrt(drive) + sqrt(|x|)*drive),
// saturated to the sample range with a clipped flag. The block takes one sample per clock
// while in_stall is low, through one magnitude stage, 24 root stages that each form one
// digit of sqrt(|x|), then multiply, sum and saturate stages; a stalled output lets the
// pipeline close its bubbles before it pushes back on the input. A write to drive starts a
// digit-serial root of the new value; while it runs, cfg_ready is low and the input is
// stalled.
module sqrt_waveshaper_distortion (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  swd_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output swd_pkg::out_item_t           out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [swd_pkg::DRIVE_W-1:0]  cfg_data
);

	localparam int N = swd_pkg::ROOT_N;

	logic                            busy;
	logic [swd_pkg::DRIVE_W-1:0]     drive;
	logic [swd_pkg::DROOT_W-1:0]     drive_root;

	logic                            valid_s0;
	swd_pkg::root_stage_t            data_s0;
	logic [swd_pkg::SAMPLE_W-1:0]    raw;

	logic [N:0]                      vld;
	swd_pkg::root_stage_t            dat [0:N];
	logic [N+1:0]                    rdy;

	assign cfg_ready = !busy;

	swd_drive_root u_drive_root (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_valid && !busy),
		.wr_data    (cfg_data),
		.busy       (busy),
		.drive      (drive),
		.drive_root (drive_root)
	);

	assign rdy[0]   = !valid_s0 || rdy[1];
	assign in_stall = busy || !rdy[0];
	assign raw      = in_data.sample_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (rdy[0]) begin
			valid_s0 <= in_valid && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			data_s0.neg       <= raw[swd_pkg::SAMPLE_W-1];
			data_s0.mag       <= raw[swd_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
			data_s0.block_end <= in_data.block_end;
			data_s0.rem       <= '0;
			data_s0.root      <= '0;
		end
	end

	assign vld[0] = valid_s0;
	assign dat[0] = data_s0;

	for (genvar k = 1; k <= N; k++) begin : g_root
		swd_root_step #(.K(k - 1)) u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (vld[k-1]),
			.up_data    (dat[k-1]),
			.up_ready   (rdy[k]),
			.down_valid (vld[k]),
			.down_data  (dat[k]),
			.down_ready (rdy[k+1])
		);
	end

	swd_shape u_shape (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (vld[N]),
		.up_data    (dat[N]),
		.up_ready   (rdy[N+1]),
		.drive      (drive),
		.drive_root (drive_root),
		.out_valid  (out_valid),
		.out_data   (out_data),
		.out_stall  (out_stall)
	);

endmodule

>>> src/swd_root_step.sv
module swd_root_step #(
	parameter int K = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	input  swd_pkg::root_stage_t up_data,
	output logic                 up_ready,
	output logic                 down_valid,
	output swd_pkg::root_stage_t down_data,
	input  logic                 down_ready
);

	logic                          valid_sk;
	swd_pkg::root_stage_t          data_sk;
	swd_pkg::root_stage_t          next;
	logic [2*swd_pkg::ROOT_N-1:0]  rad;
	logic [1:0]                    pair;
	logic [swd_pkg::REM_W+1:0]     cur;
	logic [swd_pkg::REM_W+1:0]     trial;
	logic [swd_pkg::REM_W+1:0]     diff;

	// radicand is the magnitude scaled by 2^frac, one digit pair per stage
	always_comb begin
		rad   = {1'b0, up_data.mag, {swd_pkg::FRAC_S{1'b0}}};
		pair  = rad[2*(swd_pkg::ROOT_N-1-K) +: 2];
		cur   = {up_data.rem, pair};
		trial = {2'b00, up_data.root, 2'b01};
		diff  = cur - trial;
		next  = up_data;
		if (cur >= trial) begin
			next.rem  = diff[swd_pkg::REM_W-1:0];
			next.root = {up_data.root[swd_pkg::ROOT_N-2:0], 1'b1};
		end else begin
			next.rem  = cur[swd_pkg::REM_W-1:0];
			next.root = {up_data.root[swd_pkg::ROOT_N-2:0], 1'b0};
		end
	end

	assign up_ready = !valid_sk || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk <= 1'b0;
		end else if (up_ready) begin
			valid_sk <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			data_sk <= next;
		end
	end

	assign down_valid = valid_sk;
	assign down_data  = data_sk;

endmodule

>>> src/swd_drive_root.sv
module swd_drive_root (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [swd_pkg::DRIVE_W-1:0]   wr_data,
	output logic                          busy,
	output logic [swd_pkg::DRIVE_W-1:0]   drive,
	output logic [swd_pkg::DROOT_W-1:0]   drive_root
);

	logic                            busy_q;
	logic [swd_pkg::DCNT_W-1:0]      cnt_q;
	logic [2*swd_pkg::DROOT_W-1:0]   rad_q;
	logic [swd_pkg::DREM_W-1:0]      rem_q;
	logic [swd_pkg::DROOT_W-1:0]     root_q;
	logic [swd_pkg::DRIVE_W-1:0]     drive_q;
	logic [swd_pkg::DROOT_W-1:0]     drive_root_q;

	logic [swd_pkg::DREM_W+1:0]      cur;
	logic [swd_pkg::DREM_W+1:0]      trial;
	logic [swd_pkg::DREM_W+1:0]      diff;
	logic [swd_pkg::DREM_W-1:0]      rem_nx;
	logic [swd_pkg::DROOT_W-1:0]     root_nx;

	// one root digit per cycle while busy
	always_comb begin
		cur   = {rem_q, rad_q[2*swd_pkg::DROOT_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		diff  = cur - trial;
		if (cur >= trial) begin
			rem_nx  = diff[swd_pkg::DREM_W-1:0];
			root_nx = {root_q[swd_pkg::DROOT_W-2:0], 1'b1};
		end else begin
			rem_nx  = cur[swd_pkg::DREM_W-1:0];
			root_nx = {root_q[swd_pkg::DROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cnt_q        <= '0;
			drive_q      <= swd_pkg::DRIVE_ONE;
			drive_root_q <= swd_pkg::DROOT_ONE;
		end else if (wr_en) begin
			busy_q  <= 1'b1;
			cnt_q   <= swd_pkg::DCNT_W'(swd_pkg::DROOT_W);
			drive_q <= wr_data;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == swd_pkg::DCNT_W'(1)) begin
				busy_q       <= 1'b0;
				drive_root_q <= root_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rad_q  <= {wr_data, {swd_pkg::FRAC_D{1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*swd_pkg::DROOT_W-3:0], 2'b00};
			rem_q  <= rem_nx;
			root_q <= root_nx;
		end
	end

	assign busy       = busy_q;
	assign drive      = drive_q;
	assign drive_root = drive_root_q;

endmodule

>>> src/swd_shape.sv
module swd_shape (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	input  swd_pkg::root_stage_t         up_data,
	output logic                         up_ready,
	input  logic [swd_pkg::DRIVE_W-1:0]  drive,
	input  logic [swd_pkg::DROOT_W-1:0]  drive_root,
	output logic                         out_valid,
	output swd_pkg::out_item_t           out_data,
	input  logic                         out_stall
);

	logic                            valid_s1;
	logic                            valid_s2;
	logic                            valid_s3;
	logic                            adv_s1;
	logic                            adv_s2;
	logic                            adv_s3;

	logic [swd_pkg::PROD1_W-1:0]     p1_s1;
	logic [swd_pkg::PROD2_W-1:0]     p2_s1;
	logic                            neg_s1;
	logic                            be_s1;

	logic [swd_pkg::MAG_W-1:0]       mag_s2;
	logic                            neg_s2;
	logic                            be_s2;

	swd_pkg::out_item_t              out_s3;

	logic [swd_pkg::PROD2_W:0]       sum;
	logic [swd_pkg::MAG_W-1:0]       lim;
	logic [swd_pkg::MAG_W-1:0]       sat;
	logic                            clip;
	logic [swd_pkg::SAMPLE_W-1:0]    val;
	swd_pkg::out_item_t              res;

	assign adv_s3   = !valid_s3 || !out_stall;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign up_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= up_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// drive terms
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			p1_s1  <= swd_pkg::PROD1_W'(up_data.mag) * swd_pkg::PROD1_W'(drive_root);
			p2_s1  <= swd_pkg::PROD2_W'(up_data.root) * swd_pkg::PROD2_W'(drive);
			neg_s1 <= up_data.neg;
			be_s1  <= up_data.block_end;
		end
	end

	assign sum = (swd_pkg::PROD2_W+1)'(p1_s1) + (swd_pkg::PROD2_W+1)'(p2_s1);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			mag_s2 <= sum[swd_pkg::PROD2_W:swd_pkg::FRAC_D];
			neg_s2 <= neg_s1;
			be_s2  <= be_s1;
		end
	end

	// saturate on magnitude, then apply sign
	always_comb begin
		lim = swd_pkg::MAG_W'(1) << swd_pkg::FRAC_S;
		if (!neg_s2) begin
			lim = lim - 1'b1;
		end
		clip = mag_s2 > lim;
		sat  = clip ? lim : mag_s2;
		val  = sat[swd_pkg::SAMPLE_W-1:0];
		res.sample_out    = neg_s2 ? -val : val;
		res.clipped       = clip;
		res.block_end_out = be_s2;
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			out_s3 <= res;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = out_s3;

endmodule

>>> src/swd_check.sv
module swd_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_stall,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  swd_pkg::out_item_t           out_data,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready
);

	// held output transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	// a drive write starts the root computation
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !cfg_ready)
		else $error("cfg_ready stayed high after drive write");

	// no sample taken while the drive root is in progress
	a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> in_stall)
		else $error("input open during drive root computation");

	// clipped results sit on a range limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clipped |->
			(out_data.sample_out == swd_pkg::SAMPLE_MAX) ||
			(out_data.sample_out == swd_pkg::SAMPLE_MIN))
		else $error("clipped result not at a range limit");

endmodule

bind sqrt_waveshaper_distortion swd_check u_swd_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
